// ===== design/vhc_pkg.sv =====
// ----------------------------------------------------------------------------
// vhc_pkg
// Shared types, constants and decode helpers for the vowel harmony checker.
// ----------------------------------------------------------------------------
package vhc_pkg;

    localparam int MAX_WORD_BYTES_DEF = 256;

    localparam int BYTE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 9;
    localparam int CODE_W  = 21;
    localparam int LWS_W   = 8;

    // requested harmony
    localparam logic [MODE_W-1:0] MODE_ANY   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FRONT = 2'd2;

    // vowel classes kept in the word state
    typedef logic [1:0] vclass_t;
    localparam vclass_t CLS_NONE  = 2'd0;
    localparam vclass_t CLS_BACK  = 2'd1;
    localparam vclass_t CLS_FRONT = 2'd2;
    localparam vclass_t CLS_LOAN  = 2'd3;

    // code points
    localparam logic [CODE_W-1:0] CP_A     = 21'h000430;
    localparam logic [CODE_W-1:0] CP_O     = 21'h00043E;
    localparam logic [CODE_W-1:0] CP_U_BAR = 21'h0004B1;
    localparam logic [CODE_W-1:0] CP_YERU  = 21'h00044B;
    localparam logic [CODE_W-1:0] CP_U     = 21'h000443;
    localparam logic [CODE_W-1:0] CP_SCHWA = 21'h0004D9;
    localparam logic [CODE_W-1:0] CP_IE    = 21'h000435;
    localparam logic [CODE_W-1:0] CP_O_BAR = 21'h0004E9;
    localparam logic [CODE_W-1:0] CP_UE    = 21'h0004AF;
    localparam logic [CODE_W-1:0] CP_I_DOT = 21'h000456;
    localparam logic [CODE_W-1:0] CP_I     = 21'h000438;
    localparam logic [CODE_W-1:0] CP_IO    = 21'h000451;
    localparam logic [CODE_W-1:0] CP_YA    = 21'h00044F;
    localparam logic [CODE_W-1:0] CP_E     = 21'h00044D;
    localparam logic [CODE_W-1:0] CP_YU    = 21'h00044E;

    typedef struct packed {
        logic back;
        logic front;
        logic loan;
        logic glide;
    } vflags_t;

    function automatic vflags_t classify(input logic [CODE_W-1:0] c);
        vflags_t f;
        f.back  = (c == CP_A) || (c == CP_O) || (c == CP_U_BAR) || (c == CP_YERU)
               || (c == CP_U);
        f.front = (c == CP_SCHWA) || (c == CP_IE) || (c == CP_O_BAR) || (c == CP_UE)
               || (c == CP_I_DOT) || (c == CP_I) || (c == CP_IO);
        f.loan  = (c == CP_YA) || (c == CP_E);
        f.glide = (c == CP_U) || (c == CP_I) || (c == CP_YU);
        return f;
    endfunction

    // continuation bytes asked for by a lead byte
    function automatic logic [1:0] extra_bytes(input logic [BYTE_W-1:0] b);
        logic [1:0] n;
        if (b[7:5] == 3'b110)
            n = 2'd1;
        else if (b[7:4] == 4'b1110)
            n = 2'd2;
        else if (b[7:3] == 5'b11110)
            n = 2'd3;
        else
            n = 2'd0;
        return n;
    endfunction

    function automatic logic [4:0] lead_bits(input logic [BYTE_W-1:0] b,
                                             input logic [1:0] need);
        logic [4:0] v;
        if (need == 2'd1)
            v = b[4:0];
        else if (need == 2'd2)
            v = {1'b0, b[3:0]};
        else
            v = {2'b00, b[2:0]};
        return v;
    endfunction

endpackage

// ===== design/vhc_if.sv =====
// ----------------------------------------------------------------------------
// vhc_if
// Valid/ready channels of the vowel harmony checker.
// ----------------------------------------------------------------------------
interface vhc_byte_if import vhc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              last_byte;
    logic [MODE_W-1:0] harmony_mode;
    logic              empty_word;

    modport source (output valid, byte_value, last_byte, harmony_mode, empty_word,
                    input ready);
    modport sink   (input valid, byte_value, last_byte, harmony_mode, empty_word,
                    output ready);
endinterface

interface vhc_result_if import vhc_pkg::*;;
    logic               valid;
    logic               ready;
    logic               harmony_ok;
    logic               word_is_back;
    logic               tail_is_back;
    logic [COUNT_W-1:0] syllable_count;
    logic [COUNT_W-1:0] char_count;

    modport source (output valid, harmony_ok, word_is_back, tail_is_back,
                    syllable_count, char_count, input ready);
    modport sink   (input valid, harmony_ok, word_is_back, tail_is_back,
                    syllable_count, char_count, output ready);
endinterface

interface vhc_cfg_if import vhc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [LWS_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/vowel_harmony_checker_unit.sv =====
// throughput: one byte per cycle unless a word end waits on a stalled result;
// one byte register then one word-state/result stage; a stalled result holds a
// word-ending byte, and the byte register takes a new byte when the result
// register is free or the held byte does not end a word
// reset: word state cleared, long_word_syllables back to 4, no result pending
// ----------------------------------------------------------------------------
// vowel_harmony_checker_unit
// Lenient UTF-8 decode of one word at a time, vowel classing, syllable and
// character counts, and a front/back harmony verdict on the last byte or empty flag.
// ----------------------------------------------------------------------------
module vowel_harmony_checker_unit import vhc_pkg::*;
#(
    parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    vhc_cfg_if.sink      cfg,
    vhc_byte_if.sink     bytes,
    vhc_result_if.source result
);

    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((MAX_WORD_BYTES < 511) ? MAX_WORD_BYTES : 511);

    // configuration
    logic [LWS_W-1:0] lws_reg;

    // byte register
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    logic [MODE_W-1:0] s1_mode_reg;
    logic              s1_empty_reg;

    // word state
    logic [1:0]         rem_reg,   rem_next;
    logic [1:0]         held_reg,  held_next;
    logic [CODE_W-1:0]  acc_reg,   acc_next;
    logic [BYTE_W-1:0]  hold0_reg, hold0_next;
    logic [BYTE_W-1:0]  hold1_reg, hold1_next;
    logic [COUNT_W-1:0] chars_reg, chars_next;
    logic [COUNT_W-1:0] syls_reg,  syls_next;
    logic               harm_reg,  harm_next;
    logic               wbf_reg,   wbf_next;
    vclass_t            prev_reg,  prev_next;
    vclass_t            last_reg,  last_next;

    // result register
    logic               out_valid_reg;
    logic               ok_reg;
    logic               wback_reg;
    logic               tback_reg;
    logic [COUNT_W-1:0] out_syls_reg;
    logic [COUNT_W-1:0] out_chars_reg;

    // handshake
    logic out_free;
    logic s1_end;
    logic s1_adv;

    assign out_free    = !out_valid_reg || result.ready;
    assign s1_end      = s1_empty_reg || s1_last_reg;
    assign s1_adv      = s1_valid_reg && (!s1_end || out_free);
    assign bytes.ready = !s1_valid_reg || s1_adv;
    assign cfg.ready   = 1'b1;

    // per-byte decode
    logic [1:0]         need_b;
    logic [1:0]         rem_t, held_t;
    logic [CODE_W-1:0]  acc_t;
    logic [BYTE_W-1:0]  hold0_t, hold1_t;
    logic               cand_valid;
    logic [CODE_W-1:0]  cand_code;
    logic               flush;
    logic               decode2;
    logic [1:0]         char_inc;
    vflags_t            fl;
    logic               vowel;
    logic [COUNT_W:0]   char_sum, syl_sum;
    logic [COUNT_W-1:0] chars_upd, syls_upd;
    logic               harm_upd, wbf_upd;
    vclass_t            prev_upd, last_upd;
    logic               wback, tback, ok;

    always_comb
    begin
        need_b     = extra_bytes(s1_byte_reg);
        rem_t      = rem_reg;
        held_t     = held_reg;
        acc_t      = acc_reg;
        hold0_t    = hold0_reg;
        hold1_t    = hold1_reg;
        cand_valid = 1'b0;
        cand_code  = '0;

        if (!s1_empty_reg)
        begin
            if (rem_reg == 2'd0)
            begin
                if (need_b == 2'd0)
                begin
                    cand_valid = 1'b1;
                    cand_code  = CODE_W'(s1_byte_reg);
                end
                else
                begin
                    rem_t  = need_b;
                    held_t = 2'd0;
                    acc_t  = CODE_W'(lead_bits(s1_byte_reg, need_b));
                end
            end
            else
            begin
                acc_t = {acc_reg[CODE_W-7:0], s1_byte_reg[5:0]};
                if (held_reg == 2'd0)
                    hold0_t = s1_byte_reg;
                else
                    hold1_t = s1_byte_reg;
                held_t = held_reg + 2'd1;
                rem_t  = rem_reg - 2'd1;
                if (rem_reg == 2'd1)
                begin
                    cand_valid = 1'b1;
                    cand_code  = acc_t;
                    held_t     = 2'd0;
                end
            end
        end

        // word cut inside a sequence: lead alone, held bytes decoded again
        flush   = s1_end && (rem_t != 2'd0);
        decode2 = flush && (held_t == 2'd2) && (extra_bytes(hold0_t) == 2'd1);
        if (decode2)
        begin
            cand_valid = 1'b1;
            cand_code  = CODE_W'({hold0_t[4:0], hold1_t[5:0]});
        end

        if (flush && !decode2)
            char_inc = held_t + 2'd1;
        else
            char_inc = {1'b0, cand_valid} + {1'b0, flush};

        fl    = classify(cand_code);
        vowel = cand_valid && (fl.back || fl.front || fl.loan);

        char_sum  = {1'b0, chars_reg} + (COUNT_W+1)'(char_inc);
        chars_upd = (char_sum >= {1'b0, COUNT_CAP}) ? COUNT_CAP : char_sum[COUNT_W-1:0];
        syl_sum   = {1'b0, syls_reg} + (COUNT_W+1)'(vowel);
        syls_upd  = (syl_sum >= {1'b0, COUNT_CAP}) ? COUNT_CAP : syl_sum[COUNT_W-1:0];

        harm_upd = harm_reg;
        wbf_upd  = wbf_reg;
        prev_upd = prev_reg;
        last_upd = last_reg;
        if (cand_valid && !fl.glide)
        begin
            if (fl.back || fl.front)
            begin
                harm_upd = 1'b1;
                wbf_upd  = fl.back;
            end
            if (vowel)
            begin
                prev_upd = last_reg;
                last_upd = fl.back ? CLS_BACK : (fl.front ? CLS_FRONT : CLS_LOAN);
            end
        end

        wback = harm_upd ? wbf_upd : 1'b1;
        if (last_upd == CLS_NONE)
            tback = 1'b1;
        else if (last_upd == CLS_LOAN)
            tback = (prev_upd == CLS_NONE) || (prev_upd == CLS_BACK);
        else
            tback = (last_upd == CLS_BACK);

        if (s1_mode_reg == MODE_ANY)
            ok = 1'b1;
        else if ((s1_mode_reg != MODE_BACK && s1_mode_reg != MODE_FRONT)
                 || chars_upd == '0)
            ok = 1'b0;
        else if (s1_mode_reg == MODE_BACK && wback)
            ok = 1'b1;
        else if (s1_mode_reg == MODE_FRONT && !wback)
            ok = 1'b1;
        else if (syls_upd >= COUNT_W'(lws_reg))
            ok = (s1_mode_reg == MODE_BACK) ? tback : !tback;
        else
            ok = 1'b0;
    end

    always_comb
    begin
        rem_next   = rem_reg;
        held_next  = held_reg;
        acc_next   = acc_reg;
        hold0_next = hold0_reg;
        hold1_next = hold1_reg;
        chars_next = chars_reg;
        syls_next  = syls_reg;
        harm_next  = harm_reg;
        wbf_next   = wbf_reg;
        prev_next  = prev_reg;
        last_next  = last_reg;
        if (s1_adv)
        begin
            if (s1_end)
            begin
                rem_next   = '0;
                held_next  = '0;
                acc_next   = '0;
                hold0_next = '0;
                hold1_next = '0;
                chars_next = '0;
                syls_next  = '0;
                harm_next  = 1'b0;
                wbf_next   = 1'b1;
                prev_next  = CLS_NONE;
                last_next  = CLS_NONE;
            end
            else
            begin
                rem_next   = rem_t;
                held_next  = held_t;
                acc_next   = acc_t;
                hold0_next = hold0_t;
                hold1_next = hold1_t;
                chars_next = chars_upd;
                syls_next  = syls_upd;
                harm_next  = harm_upd;
                wbf_next   = wbf_upd;
                prev_next  = prev_upd;
                last_next  = last_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lws_reg       <= LWS_W'(4);
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            held_reg      <= '0;
            acc_reg       <= '0;
            hold0_reg     <= '0;
            hold1_reg     <= '0;
            chars_reg     <= '0;
            syls_reg      <= '0;
            harm_reg      <= 1'b0;
            wbf_reg       <= 1'b1;
            prev_reg      <= CLS_NONE;
            last_reg      <= CLS_NONE;
        end
        else
        begin
            if (cfg.valid)
                lws_reg <= cfg.data;

            if (bytes.ready)
                s1_valid_reg <= bytes.valid;

            if (s1_adv && s1_end)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            rem_reg   <= rem_next;
            held_reg  <= held_next;
            acc_reg   <= acc_next;
            hold0_reg <= hold0_next;
            hold1_reg <= hold1_next;
            chars_reg <= chars_next;
            syls_reg  <= syls_next;
            harm_reg  <= harm_next;
            wbf_reg   <= wbf_next;
            prev_reg  <= prev_next;
            last_reg  <= last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            s1_byte_reg  <= bytes.byte_value;
            s1_last_reg  <= bytes.last_byte;
            s1_mode_reg  <= bytes.harmony_mode;
            s1_empty_reg <= bytes.empty_word;
        end
        if (s1_adv && s1_end)
        begin
            ok_reg        <= ok;
            wback_reg     <= wback;
            tback_reg     <= tback;
            out_syls_reg  <= syls_upd;
            out_chars_reg <= chars_upd;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.harmony_ok     = ok_reg;
    assign result.word_is_back   = wback_reg;
    assign result.tail_is_back   = tback_reg;
    assign result.syllable_count = out_syls_reg;
    assign result.char_count     = out_chars_reg;

    // a word end always lands in the result register
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_end |=> out_valid_reg)
        else $error("word end did not produce a result");

    // word state is clean after a word end
    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_end |=> rem_reg == 2'd0 && chars_reg == '0 && syls_reg == '0)
        else $error("word state not cleared after word end");

    a_counts_capped: assert property (@(posedge clk) disable iff (!rst_n)
        chars_reg <= COUNT_CAP && syls_reg <= chars_reg)
        else $error("counts out of range");

    // held bytes exist only inside an open sequence
    a_held_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg == 2'd0 |-> held_reg == 2'd0)
        else $error("held bytes outside a sequence");

    // nothing new enters the word state while a finished word waits on a full output
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_end && !out_free |=> $stable(chars_reg) && s1_valid_reg)
        else $error("word state moved during a result stall");

endmodule

// ===== tb/vowel_harmony_checker_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vowel_harmony_checker_unit_tb
// Drives words of UTF-8 bytes into the harmony checker through valid/ready
// channels with random idling on both sides. A behavioral predictor of the
// word state computes each summary, and the monitor compares every result
// field by field. A directed table comes first, then random words over
// several settings of long_word_syllables.
// ----------------------------------------------------------------------------
module vowel_harmony_checker_unit_tb import vhc_pkg::*;;

    localparam int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF;
    localparam int COUNT_CAP      = (MAX_WORD_BYTES < 511) ? MAX_WORD_BYTES : 511;
    localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;
    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 8;
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_ITEMS    = 195;
    localparam int LONG_HOLD      = 120;
    localparam int DRAIN_CYCLES   = 6;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_ROWS       = 24;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              last_byte;
        logic [MODE_W-1:0] harmony_mode;
        logic              empty_word;
    } word_item_t;

    typedef struct packed {
        logic               harmony_ok;
        logic               word_is_back;
        logic               tail_is_back;
        logic [COUNT_W-1:0] syllable_count;
        logic [COUNT_W-1:0] char_count;
    } word_summary_t;

    typedef struct packed {
        word_item_t    item;
        logic          fixed;
        word_summary_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    vhc_cfg_if    cfg_ch ();
    vhc_byte_if   byte_ch ();
    vhc_result_if res_ch ();

    vowel_harmony_checker_unit #(
        .MAX_WORD_BYTES(MAX_WORD_BYTES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .bytes (byte_ch),
        .result(res_ch)
    );

    // predictor state
    logic [LWS_W-1:0]  lws_model;
    logic [1:0]        pend_left;
    logic [1:0]        pend_held;
    logic [CODE_W-1:0] pend_code;
    logic [BYTE_W-1:0] pend_lead;
    logic [BYTE_W-1:0] pend_bytes [4];
    int                n_chars;
    int                n_syl;
    bit                harm_seen;
    bit                back_flag;
    vclass_t           cls_prev;
    vclass_t           cls_last;

    word_summary_t     summaries_due [$];
    word_item_t        word_items [$];
    logic [BYTE_W-1:0] word_bytes [$];
    dir_row_t          dir_table [DIR_ROWS];

    int mismatch_count;
    int items_sent;
    int holds_wanted;
    int holds_done;
    bit send_quiet;
    bit recv_quiet;

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    initial begin
        #2000000;
        $display("FAIL vowel_harmony_checker_unit");
        $finish;
    end

    function automatic void clear_word_state();
        pend_left = '0;
        pend_held = '0;
        pend_code = '0;
        pend_lead = '0;
        for (int i = 0; i < 4; i++)
            pend_bytes[i] = '0;
        n_chars   = 0;
        n_syl     = 0;
        harm_seen = 1'b0;
        back_flag = 1'b1;
        cls_prev  = CLS_NONE;
        cls_last  = CLS_NONE;
    endfunction

    function automatic void count_char(input logic [CODE_W-1:0] c);
        bit bk;
        bit fr;
        bit ln;
        bit gl;
        bk = c inside {CP_A, CP_O, CP_U_BAR, CP_YERU, CP_U};
        fr = c inside {CP_SCHWA, CP_IE, CP_O_BAR, CP_UE, CP_I_DOT, CP_I, CP_IO};
        ln = c inside {CP_YA, CP_E};
        gl = c inside {CP_U, CP_I, CP_YU};
        if (n_chars < COUNT_CAP)
            n_chars++;
        if ((bk || fr || ln) && n_syl < COUNT_CAP)
            n_syl++;
        // glides never steer harmony; those that are also vowels count as syllables
        if (!gl)
        begin
            if (bk || fr)
            begin
                harm_seen = 1'b1;
                back_flag = bk;
            end
            if (bk || fr || ln)
            begin
                cls_prev = cls_last;
                cls_last = bk ? CLS_BACK : (fr ? CLS_FRONT : CLS_LOAN);
            end
        end
    endfunction

    function automatic int lead_extra(input logic [BYTE_W-1:0] b);
        int n;
        casez (b)
            8'b110?????: n = 1;
            8'b1110????: n = 2;
            8'b11110???: n = 3;
            default:     n = 0;
        endcase
        return n;
    endfunction

    function automatic logic [CODE_W-1:0] lead_payload(input logic [BYTE_W-1:0] b,
                                                       input int need);
        logic [CODE_W-1:0] v;
        if (need == 1)
            v = {16'd0, b[4:0]};
        else if (need == 2)
            v = {17'd0, b[3:0]};
        else
            v = {18'd0, b[2:0]};
        return v;
    endfunction

    function automatic void feed_byte(input logic [BYTE_W-1:0] b);
        int need;
        if (pend_left == 2'd0)
        begin
            need = lead_extra(b);
            if (need == 0)
                count_char({13'd0, b});
            else
            begin
                pend_lead = b;
                pend_left = 2'(need);
                pend_held = 2'd0;
                pend_code = lead_payload(b, need);
            end
        end
        else
        begin
            pend_code = {pend_code[CODE_W-7:0], b[5:0]};
            pend_bytes[pend_held] = b;
            pend_held = pend_held + 2'd1;
            pend_left = pend_left - 2'd1;
            if (pend_left == 2'd0)
            begin
                count_char(pend_code);
                pend_held = 2'd0;
            end
        end
    endfunction

    // word ended inside a sequence: the lead alone, then the held bytes again
    function automatic void flush_cut_seq();
        int n;
        int j;
        int need;
        logic [BYTE_W-1:0] b;
        logic [CODE_W-1:0] c;
        if (pend_left != 2'd0)
        begin
            count_char({13'd0, pend_lead});
            n = pend_held;
            j = 0;
            while (j < n)
            begin
                b = pend_bytes[j % 4];
                need = lead_extra(b);
                if (need > 0 && j + need < n)
                begin
                    c = lead_payload(b, need);
                    for (int k = 1; k <= need; k++)
                        c = {c[CODE_W-7:0], pend_bytes[(j + k) % 4][5:0]};
                    count_char(c);
                    j = j + need + 1;
                end
                else
                begin
                    count_char({13'd0, b});
                    j++;
                end
            end
            pend_left = 2'd0;
            pend_held = 2'd0;
        end
    endfunction

    function automatic void predict_summary(input word_item_t it, output bit has,
                                            output word_summary_t s);
        bit wb;
        bit tb;
        bit ok;
        s = '0;
        if (!it.empty_word)
            feed_byte(it.byte_value);
        has = it.empty_word || it.last_byte;
        if (has)
        begin
            flush_cut_seq();
            wb = harm_seen ? back_flag : 1'b1;
            if (cls_last == CLS_NONE)
                tb = 1'b1;
            else if (cls_last == CLS_LOAN)
                tb = (cls_prev == CLS_NONE) || (cls_prev == CLS_BACK);
            else
                tb = (cls_last == CLS_BACK);
            if (it.harmony_mode == MODE_ANY)
                ok = 1'b1;
            else if (it.harmony_mode == MODE_RSVD || n_chars == 0)
                ok = 1'b0;
            else if (it.harmony_mode == MODE_BACK && wb)
                ok = 1'b1;
            else if (it.harmony_mode == MODE_FRONT && !wb)
                ok = 1'b1;
            else if (n_syl >= lws_model)
                ok = (it.harmony_mode == MODE_BACK) ? tb : !tb;
            else
                ok = 1'b0;
            s.harmony_ok     = ok;
            s.word_is_back   = wb;
            s.tail_is_back   = tb;
            s.syllable_count = COUNT_W'(n_syl);
            s.char_count     = COUNT_W'(n_chars);
            clear_word_state();
        end
    endfunction

    function automatic string describe(input word_summary_t s);
        return $sformatf("ok=%0b back=%0b tail=%0b syl=%0d chars=%0d", s.harmony_ok,
                         s.word_is_back, s.tail_is_back, s.syllable_count, s.char_count);
    endfunction

    function automatic dir_row_t feed(input logic [BYTE_W-1:0] b, input logic last,
                                      input logic [MODE_W-1:0] mode, input logic empty);
        dir_row_t r;
        r.item  = '{b, last, mode, empty};
        r.fixed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic dir_row_t typed(input logic [BYTE_W-1:0] b, input logic last,
                                       input logic [MODE_W-1:0] mode, input logic empty,
                                       input logic ok, input logic wb, input logic tb,
                                       input int syl, input int chars);
        dir_row_t r;
        r.item  = '{b, last, mode, empty};
        r.fixed = 1'b1;
        r.want  = '{ok, wb, tb, COUNT_W'(syl), COUNT_W'(chars)};
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] cont_byte(input logic [5:0] v);
        logic [1:0] top;
        // continuation tag bits are not checked, so scramble them now and then
        top = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
        return {top, v};
    endfunction

    function automatic logic [CODE_W-1:0] pick_vowel();
        logic [CODE_W-1:0] c;
        case ($urandom_range(0, 14))
            0:       c = CP_A;
            1:       c = CP_O;
            2:       c = CP_U_BAR;
            3:       c = CP_YERU;
            4:       c = CP_U;
            5:       c = CP_SCHWA;
            6:       c = CP_IE;
            7:       c = CP_O_BAR;
            8:       c = CP_UE;
            9:       c = CP_I_DOT;
            10:      c = CP_I;
            11:      c = CP_IO;
            12:      c = CP_YA;
            13:      c = CP_E;
            default: c = CP_YU;
        endcase
        return c;
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input bit closing);
        logic [MODE_W-1:0] m;
        if (!closing)
            m = MODE_W'($urandom_range(0, 3));
        else if ($urandom_range(0, 9) == 0)
            m = MODE_RSVD;
        else
            m = MODE_W'($urandom_range(0, 2));
        return m;
    endfunction

    task automatic push_code(input logic [CODE_W-1:0] c);
        if (c < 21'h80)
            word_bytes.push_back(c[7:0]);
        else if (c < 21'h800)
        begin
            word_bytes.push_back({3'b110, c[10:6]});
            word_bytes.push_back(cont_byte(c[5:0]));
        end
        else if (c < 21'h10000)
        begin
            word_bytes.push_back({4'b1110, c[15:12]});
            word_bytes.push_back(cont_byte(c[11:6]));
            word_bytes.push_back(cont_byte(c[5:0]));
        end
        else
        begin
            word_bytes.push_back({5'b11110, c[20:18]});
            word_bytes.push_back(cont_byte(c[17:12]));
            word_bytes.push_back(cont_byte(c[11:6]));
            word_bytes.push_back(cont_byte(c[5:0]));
        end
    endtask

    task automatic push_random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            push_code(pick_vowel());
        else if (r < 58)
            push_code(CODE_W'($urandom_range(0, 'h7F)));
        else if (r < 70)
            push_code(CODE_W'($urandom_range('h80, 'h7FF)));
        else if (r < 80)
            push_code(CODE_W'($urandom_range('h800, 'hFFFF)));
        else if (r < 86)
            push_code(CODE_W'($urandom_range('h10000, 'h1FFFFF)));
        else
            word_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    endtask

    // lead byte followed by fewer bytes than it asks for
    task automatic push_partial();
        int need;
        need = $urandom_range(1, 3);
        if (need == 1)
            word_bytes.push_back({3'b110, 5'($urandom_range(0, 31))});
        else if (need == 2)
            word_bytes.push_back({4'b1110, 4'($urandom_range(0, 15))});
        else
            word_bytes.push_back({5'b11110, 3'($urandom_range(0, 7))});
        repeat ($urandom_range(0, need - 1))
        begin
            if ($urandom_range(0, 1) == 1)
                word_bytes.push_back({3'b110, 5'($urandom_range(0, 31))});
            else
                word_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic finish_word(input bit end_by_empty);
        word_item_t it;
        foreach (word_bytes[i])
        begin
            it.byte_value   = word_bytes[i];
            it.last_byte    = !end_by_empty && (i == word_bytes.size() - 1);
            it.harmony_mode = pick_mode(it.last_byte);
            it.empty_word   = 1'b0;
            word_items.push_back(it);
        end
        if (end_by_empty)
        begin
            it.byte_value   = BYTE_W'($urandom_range(0, 255));
            it.last_byte    = 1'($urandom_range(0, 1));
            it.harmony_mode = pick_mode(1'b1);
            it.empty_word   = 1'b1;
            word_items.push_back(it);
        end
        word_bytes.delete();
    endtask

    task automatic compose_word();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind >= 91)
        begin
            repeat ($urandom_range(1, 8))
                word_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        else if (kind < 75 || kind >= 83)
        begin
            repeat ($urandom_range(1, 10))
                push_random_char();
            if ((kind >= 65 && kind < 75) || (kind >= 83 && $urandom_range(0, 1) == 1))
                push_partial();
        end
        // 75..90 end on the empty flag, 75..82 with no byte at all
        finish_word(kind >= 75 && kind < 91);
    endtask

    task automatic compose_long(input bit vowels_only, input int chars);
        repeat (chars)
        begin
            if (vowels_only)
                push_code(pick_vowel());
            else
                push_random_char();
        end
        finish_word(1'b0);
    endtask

    task automatic send_item(input word_item_t it, input bit fixed, input word_summary_t want);
        int gap;
        bit has;
        word_summary_t pred;
        gap = send_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.byte_value   <= it.byte_value;
        byte_ch.last_byte    <= it.last_byte;
        byte_ch.harmony_mode <= it.harmony_mode;
        byte_ch.empty_word   <= it.empty_word;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        predict_summary(it, has, pred);
        if (has)
            summaries_due.push_back(fixed ? want : pred);
        items_sent++;
    endtask

    task automatic send_word();
        if ($urandom_range(0, 15) == 0)
            send_quiet = !send_quiet;
        while (word_items.size() != 0)
            send_item(word_items.pop_front(), 1'b0, '0);
    endtask

    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (summaries_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_lws(input logic [LWS_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        lws_model = v;
    endtask

    // result side: random stalls, quiet stretches and requested long holds
    initial begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                recv_quiet = !recv_quiet;
            if (holds_wanted > holds_done)
            begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            stall = recv_quiet ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        word_summary_t got;
        word_summary_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.harmony_ok     = res_ch.harmony_ok;
            got.word_is_back   = res_ch.word_is_back;
            got.tail_is_back   = res_ch.tail_is_back;
            got.syllable_count = res_ch.syllable_count;
            got.char_count     = res_ch.char_count;
            if (summaries_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with no word pending: %s", $realtime, describe(got));
            end
            else
            begin
                want = summaries_due.pop_front();
                if (got.harmony_ok !== want.harmony_ok
                    || got.word_is_back !== want.word_is_back
                    || got.tail_is_back !== want.tail_is_back
                    || got.syllable_count !== want.syllable_count
                    || got.char_count !== want.char_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch expected %s got %s", $realtime,
                                 describe(want), describe(got));
                end
            end
        end
    end

    initial begin : stimulus
        int start;
        bit paused;
        logic [LWS_W-1:0] lws;

        mismatch_count = 0;
        items_sent     = 0;
        holds_wanted   = 0;
        holds_done     = 0;
        send_quiet     = 1'b0;
        recv_quiet     = 1'b0;

        rst_n                <= 1'b0;
        byte_ch.valid        <= 1'b0;
        byte_ch.byte_value   <= '0;
        byte_ch.last_byte    <= 1'b0;
        byte_ch.harmony_mode <= MODE_ANY;
        byte_ch.empty_word   <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.data          <= '0;
        lws_model = LWS_W'(4);
        clear_word_state();

        dir_table = '{
            // empty words after reset
            typed(8'hA5, 1'b0, MODE_ANY,   1'b1, 1'b1, 1'b1, 1'b1, 0, 0),
            typed(8'h5A, 1'b1, MODE_BACK,  1'b1, 1'b0, 1'b1, 1'b1, 0, 0),
            typed(8'hFF, 1'b0, MODE_RSVD,  1'b1, 1'b0, 1'b1, 1'b1, 0, 0),
            // single byte extremes
            typed(8'h00, 1'b1, MODE_ANY,   1'b0, 1'b1, 1'b1, 1'b1, 0, 1),
            typed(8'hFF, 1'b1, MODE_BACK,  1'b0, 1'b1, 1'b1, 1'b1, 0, 1),
            // back vowel then loan vowel
            feed(8'hD0, 1'b0, MODE_FRONT, 1'b0),
            feed(8'hB0, 1'b0, MODE_ANY,   1'b0),
            feed(8'hD1, 1'b0, MODE_RSVD,  1'b0),
            feed(8'h8D, 1'b1, MODE_BACK,  1'b0),
            // front vowel
            feed(8'hD3, 1'b0, MODE_BACK,  1'b0),
            feed(8'h99, 1'b1, MODE_FRONT, 1'b0),
            // four byte character
            feed(8'hF0, 1'b0, MODE_ANY,   1'b0),
            feed(8'h9F, 1'b0, MODE_ANY,   1'b0),
            feed(8'h98, 1'b0, MODE_ANY,   1'b0),
            feed(8'h80, 1'b1, MODE_FRONT, 1'b0),
            // cut-off lead, held bytes decode again as a vowel
            feed(8'hF0, 1'b0, MODE_ANY,   1'b0),
            feed(8'hD0, 1'b0, MODE_ANY,   1'b0),
            feed(8'hB0, 1'b1, MODE_BACK,  1'b0),
            // empty flag ends a word in the middle of a sequence
            feed(8'hD0, 1'b0, MODE_BACK,  1'b0),
            feed(8'h00, 1'b0, MODE_ANY,   1'b1),
            // last and empty together, the byte is dropped
            feed(8'h41, 1'b0, MODE_ANY,   1'b0),
            feed(8'hFF, 1'b1, MODE_BACK,  1'b1),
            // glide with the unused mode
            feed(8'hD0, 1'b0, MODE_ANY,   1'b0),
            feed(8'hB8, 1'b1, MODE_RSVD,  1'b0)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows run on the reset value of the register
        foreach (dir_table[i])
            send_item(dir_table[i].item, dir_table[i].fixed, dir_table[i].want);

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0:       lws = LWS_W'(1);
                1:       lws = LWS_W'(255);
                2:       lws = LWS_W'(3);
                4:       lws = LWS_W'(2);
                default: lws = LWS_W'($urandom_range(1, 255));
            endcase
            write_lws(lws);
            if (ph == 2 || ph == 5)
                holds_wanted++;
            start  = items_sent;
            paused = 1'b0;
            // saturating words: characters first, then syllables
            if (ph == 0)
            begin
                compose_long(1'b0, 280);
                send_word();
            end
            if (ph == 1)
            begin
                compose_long(1'b1, 300);
                send_word();
            end
            while (items_sent - start < PHASE_ITEMS)
            begin
                if (ph == 3 && !paused && items_sent - start >= PHASE_ITEMS / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                compose_word();
                send_word();
            end
        end

        drain_results();
        if (mismatch_count == 0 && summaries_due.size() == 0)
            $display("PASS vowel_harmony_checker_unit");
        else
            $display("FAIL vowel_harmony_checker_unit");
        $finish;
    end

endmodule
